@@ rtl/dds_pkg.sv @@
package dds_pkg;

    localparam int TABLE_INDEX_BITS_DEF = 10;
    localparam int PHASE_WIDTH_DEF      = 32;
    localparam int HALF_SWING           = 2047;
    localparam int DAC_TOP              = 4095;
    localparam int FULL_SCALE           = 32767;
    localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C234;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REG_TUNING_WORD = 2'd0;
    localparam logic [1:0] REG_PHASE_SHIFT = 2'd1;
    localparam logic [1:0] REG_AMPLITUDE   = 2'd2;
    localparam logic [1:0] REG_DC_LEVEL    = 2'd3;

    typedef struct packed {
        logic [31:0] tuning_word;
        logic [31:0] phase_shift;
        logic [14:0] amplitude_q15;
        logic [11:0] dc_level;
    } cfg_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } qstat_t;

    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic signed [31:0] quarter_sine(int unsigned k, int unsigned tib);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = ((PI_Q62 >> tib) << 1) * 64'(k);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        term = mul_q62(term, x2) / 64'd6;   sum = sum - term;
        term = mul_q62(term, x2) / 64'd20;  sum = sum + term;
        term = mul_q62(term, x2) / 64'd42;  sum = sum - term;
        term = mul_q62(term, x2) / 64'd72;  sum = sum + term;
        term = mul_q62(term, x2) / 64'd110; sum = sum - term;
        term = mul_q62(term, x2) / 64'd156; sum = sum + term;
        term = mul_q62(term, x2) / 64'd210; sum = sum - term;
        term = mul_q62(term, x2) / 64'd272; sum = sum + term;
        term = mul_q62(term, x2) / 64'd342; sum = sum - term;
        term = mul_q62(term, x2) / 64'd420; sum = sum + term;
        term = mul_q62(term, x2) / 64'd506; sum = sum - term;
        term = mul_q62(term, x2) / 64'd600; sum = sum + term;
        r = mul_q62(sum, 64'(FULL_SCALE));
        return $signed(r[31:0]);
    endfunction

    function automatic logic signed [15:0] sine_value(int unsigned i, int unsigned tib);
        int unsigned quarter;
        int unsigned quad;
        int unsigned r;
        logic signed [31:0] v;
        quarter = 1 << (tib - 2);
        quad    = i >> (tib - 2);
        r       = i & (quarter - 1);
        if (quad[0])
        begin
            v = (r == 0) ? 32'(FULL_SCALE) : quarter_sine(quarter - r, tib);
        end
        else
        begin
            v = quarter_sine(r, tib);
        end
        if (quad[1])
        begin
            v = -v;
        end
        return v[15:0];
    endfunction

endpackage

@@ rtl/dds_front.sv @@
module dds_front
    import dds_pkg::*;
#(
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF,
    parameter int PHASE_WIDTH      = PHASE_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        clear_phase,
    output logic                        q_push,
    output logic [TABLE_INDEX_BITS-1:0] q_data,
    input  qstat_t                      q_stat
);

    logic [PHASE_WIDTH-1:0] acc_reg;
    logic [PHASE_WIDTH-1:0] acc_next;
    logic [PHASE_WIDTH-1:0] phase;
    logic [PHASE_WIDTH-1:0] tw_ext;
    logic [PHASE_WIDTH-1:0] sh_ext;

    assign tw_ext   = PHASE_WIDTH'(cfg.tuning_word);
    assign sh_ext   = PHASE_WIDTH'(cfg.phase_shift);
    assign in_ready = !q_stat.full;
    assign q_push   = in_valid && !q_stat.full;
    assign acc_next = (clear_phase ? '0 : acc_reg) + tw_ext;
    assign phase    = acc_next + sh_ext;
    assign q_data   = phase[PHASE_WIDTH-1 -: TABLE_INDEX_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (q_push)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

@@ rtl/dds_queue.sv @@
module dds_queue
    import dds_pkg::*;
#(
    parameter int WIDTH = TABLE_INDEX_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output qstat_t           stat
);

    logic [WIDTH-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push_ok;
    logic              pop_ok;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;
    assign push_ok    = push && !stat.full;
    assign pop_ok     = pop && !stat.empty;
    assign count_next = count_reg + QCNT_W'(push_ok) - QCNT_W'(pop_ok);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/dds_back.sv @@
module dds_back
    import dds_pkg::*;
#(
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic                        q_valid,
    input  logic [TABLE_INDEX_BITS-1:0] q_data,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [11:0]                 dac_code
);

    localparam int ROM_SIZE = 1 << TABLE_INDEX_BITS;
    localparam logic [14:0] HALF_SWING_W = 15'(HALF_SWING);
    localparam logic signed [17:0] DAC_TOP_S = 18'(DAC_TOP);

    function automatic logic [14:0] div_full_scale(logic [29:0] v);
        logic [14:0] q_est;
        logic [15:0] rem;
        logic [15:0] q;
        q_est = v[29:15];
        rem   = {1'b0, v[14:0]} + {1'b0, q_est};
        q     = {1'b0, q_est} + ((rem >= 16'(FULL_SCALE)) ? 16'd1 : 16'd0);
        return q[14:0];
    endfunction

    logic signed [15:0] rom_w [ROM_SIZE];

    for (genvar g = 0; g < ROM_SIZE; g++)
    begin : g_rom
        localparam logic signed [15:0] ENTRY = sine_value(g, TABLE_INDEX_BITS);
        assign rom_w[g] = ENTRY;
    end

    logic               adv;
    logic               a_valid_reg;
    logic               b_valid_reg;
    logic               c_valid_reg;
    logic               d_valid_reg;
    logic               out_valid_reg;
    logic signed [15:0] rom_reg;
    logic [14:0]        mag_a;
    logic               neg_b_reg;
    logic [29:0]        prod1_reg;
    logic               neg_c_reg;
    logic [14:0]        q1_reg;
    logic               neg_d_reg;
    logic [29:0]        prod2_reg;
    logic [14:0]        q2;
    logic signed [17:0] sum;
    logic signed [17:0] clamped;
    logic [11:0]        dac_reg;
    logic [11:0]        dac_next;

    assign adv       = !out_valid_reg || out_ready;
    assign q_pop     = adv && q_valid;
    assign out_valid = out_valid_reg;
    assign dac_code  = dac_reg;

    assign mag_a = rom_reg[15] ? 15'(-rom_reg) : rom_reg[14:0];
    assign q2    = div_full_scale(prod2_reg);
    assign sum   = neg_d_reg ? ($signed({6'd0, cfg.dc_level}) - $signed({3'd0, q2}))
                             : ($signed({6'd0, cfg.dc_level}) + $signed({3'd0, q2}));

    always_comb
    begin
        if (sum < 0)
        begin
            clamped = '0;
        end
        else if (sum > DAC_TOP_S)
        begin
            clamped = DAC_TOP_S;
        end
        else
        begin
            clamped = sum;
        end
        dac_next = clamped[11:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rom_reg   <= rom_w[q_data];
            neg_b_reg <= rom_reg[15];
            prod1_reg <= 30'(mag_a) * 30'(cfg.amplitude_q15);
            neg_c_reg <= neg_b_reg;
            q1_reg    <= div_full_scale(prod1_reg);
            neg_d_reg <= neg_c_reg;
            prod2_reg <= 30'(q1_reg) * 30'(HALF_SWING_W);
            dac_reg   <= dac_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= q_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
        end
    end

endmodule

@@ rtl/dds_sine_sample_generator_unit.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_ready    clear_phase
// out       out_valid / out_ready  dac_code
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while the queue has room; the accumulator add is the only loop.
// A word is written into the queue at the accepting edge, then goes through ROM read,
// multiply, correct, multiply, correct and clamp into the output register.
// Reset clears the accumulator, queue and stage valids, and loads register defaults.
// An output stall holds the back pipeline; the front keeps taking words until the
// 4-entry queue fills. cfg_ready is always high.
module dds_sine_sample_generator_unit
    import dds_pkg::*;
#(
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF,
    parameter int PHASE_WIDTH      = PHASE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        clear_phase,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] dac_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t                        cfg_reg;
    logic                        q_push;
    logic                        q_pop;
    logic [TABLE_INDEX_BITS-1:0] q_wdata;
    logic [TABLE_INDEX_BITS-1:0] q_rdata;
    qstat_t                      q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tuning_word   <= '0;
            cfg_reg.phase_shift   <= '0;
            cfg_reg.amplitude_q15 <= 15'(FULL_SCALE);
            cfg_reg.dc_level      <= 12'd2048;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TUNING_WORD: cfg_reg.tuning_word   <= cfg_data;
                REG_PHASE_SHIFT: cfg_reg.phase_shift   <= cfg_data;
                REG_AMPLITUDE:   cfg_reg.amplitude_q15 <= cfg_data[14:0];
                REG_DC_LEVEL:    cfg_reg.dc_level      <= cfg_data[11:0];
                default:         cfg_reg               <= cfg_reg;
            endcase
        end
    end

    dds_front #(
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
        .PHASE_WIDTH      (PHASE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .clear_phase (clear_phase),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_stat      (q_stat)
    );

    dds_queue #(
        .WIDTH (TABLE_INDEX_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    dds_back #(
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (!q_stat.empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dac_code  (dac_code)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + QCNT_W'(1)))
        else $error("queue count lost a word");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_pop) |=> (q_stat.count == $past(q_stat.count)))
        else $error("queue count drift on push and pop");

endmodule
